/* hdl/olib_pkg.sv */
// Shared constants, types and codes for the ordered list insert buffer.
package olib_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int POS_W      = 5;
  localparam int LEN_W      = 5;
  localparam int VAL_W      = 32;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [LEN_W-1:0]        len_t;
  typedef logic [CMP_W-1:0]        cmp_t;

  typedef enum logic [1:0] {
    OP_FRONT = 2'd0,
    OP_BACK  = 2'd1,
    OP_AT    = 2'd2,
    OP_DUMP  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What a cell loads on the next edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_FROM_HEAD
  } cell_mode_t;

endpackage

/* hdl/olib_req_if.sv */
// Request channel: operation words into the list buffer.
interface olib_req_if;
  import olib_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  value_t  value;
  pos_t    position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

/* hdl/olib_rsp_if.sv */
// Response channel: status and dump words out of the list buffer.
interface olib_rsp_if;
  import olib_pkg::*;

  logic    valid;
  logic    ready;
  value_t  entry_value;
  logic    entry_last;
  len_t    list_length;
  status_t status;

  modport source (output valid, output entry_value, output entry_last, output list_length,
                  output status, input ready);
  modport sink   (input valid, input entry_value, input entry_last, input list_length,
                  input status, output ready);
endinterface

/* hdl/olib_cell.sv */
// One storage cell of the list chain: holds an entry and takes a neighbor's on command.
module olib_cell (
  input  logic                clk,
  input  olib_pkg::cell_mode_t mode,
  input  olib_pkg::value_t    left,
  input  olib_pkg::value_t    right,
  input  olib_pkg::value_t    head,
  input  olib_pkg::value_t    load_value,
  output olib_pkg::value_t    q
);
  import olib_pkg::*;

  value_t q_next;

  always_comb begin
    case (mode)
      CELL_LOAD:       q_next = load_value;
      CELL_FROM_LEFT:  q_next = left;
      CELL_FROM_RIGHT: q_next = right;
      CELL_FROM_HEAD:  q_next = head;
      default:         q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

/* hdl/ordered_list_insert_buffer_core.sv */
// Top level of the ordered list insert buffer: cell chain plus control.
//
//   channel | dir | fields                                          | words per op
//   --------+-----+-------------------------------------------------+--------------------
//   req     | in  | opcode, value, position                         | 1
//   rsp     | out | entry_value, entry_last, list_length, status    | 1; dump: length or 1
//
// An insert shifts the cells past the insert point toward the back in parallel,
// and the status word is registered in the output register.
// A dump of N entries rotates the chain toward the front once per emitted word,
// so after N steps the list is back in place.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
// A stalled rsp holds the output register; req is taken only while idle and
// the output register is free or being drained.
module ordered_list_insert_buffer_core (
  input  logic        clk,
  input  logic        rst,
  olib_req_if.sink    req,
  olib_rsp_if.source  rsp
);
  import olib_pkg::*;

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t     state;
  count_t     count;
  count_t     count_next;
  count_t     dump_idx;
  value_t     cell_q   [LIST_DEPTH];
  cell_mode_t cell_mode[LIST_DEPTH];

  logic    slot_free;
  logic    in_fire;
  logic    dump_step;
  logic    dump_last;
  logic    is_full;
  logic    pos_ok;
  logic    do_ins;
  cmp_t    ins_idx;
  cmp_t    pos_ext;
  cmp_t    cnt_ext;
  count_t  tail_idx;
  status_t ins_status;

  assign slot_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign in_fire   = req.valid && req.ready;
  assign dump_step = (state == S_DUMP) && slot_free;
  assign tail_idx  = count - count_t'(1);
  assign dump_last = (dump_idx == tail_idx);

  assign is_full = (count == count_t'(LIST_DEPTH));
  assign pos_ext = cmp_t'(req.position);
  assign cnt_ext = cmp_t'(count);
  assign pos_ok  = (pos_ext == cmp_t'(1)) ||
                   ((pos_ext >= cmp_t'(2)) && (pos_ext <= cnt_ext));

  always_comb begin
    ins_idx    = '0;
    ins_status = ST_OK;
    do_ins     = 1'b0;
    case (req.opcode)
      OP_FRONT: ins_idx = '0;
      OP_BACK:  ins_idx = cnt_ext;
      OP_AT:    ins_idx = pos_ext - cmp_t'(1);
      default:  ins_idx = '0;
    endcase
    if (is_full) begin
      ins_status = ST_FULL;
    end else if ((req.opcode == OP_AT) && !pos_ok) begin
      ins_status = ST_RANGE;
    end else begin
      do_ins = in_fire && (req.opcode != OP_DUMP);
    end
  end

  assign count_next = do_ins ? count + count_t'(1) : count;

  // Insert: cells past the gap take their left neighbor, the gap loads the value.
  // Dump: rotate toward the front; the tail of the list takes the head.
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      cell_mode[i] = CELL_HOLD;
      if (do_ins) begin
        if (cmp_t'(i) > ins_idx) begin
          cell_mode[i] = CELL_FROM_LEFT;
        end else if (cmp_t'(i) == ins_idx) begin
          cell_mode[i] = CELL_LOAD;
        end
      end else if (dump_step) begin
        cell_mode[i] = (count_t'(i) == tail_idx) ? CELL_FROM_HEAD : CELL_FROM_RIGHT;
      end
    end
  end

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    value_t left_v;
    value_t right_v;
    if (g == 0) begin : g_first
      assign left_v = req.value;
    end else begin : g_mid
      assign left_v = cell_q[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_lastc
      assign right_v = cell_q[0];
    end else begin : g_notlast
      assign right_v = cell_q[g+1];
    end
    olib_cell u_cell (
      .clk        (clk),
      .mode       (cell_mode[g]),
      .left       (left_v),
      .right      (right_v),
      .head       (cell_q[0]),
      .load_value (req.value),
      .q          (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      count           <= '0;
      dump_idx        <= '0;
      rsp.valid       <= 1'b0;
      rsp.entry_value <= '0;
      rsp.entry_last  <= 1'b0;
      rsp.list_length <= '0;
      rsp.status      <= ST_OK;
    end else begin
      count <= count_next;
      if (in_fire) begin
        if (req.opcode == OP_DUMP) begin
          if (count == '0) begin
            rsp.valid       <= 1'b1;
            rsp.entry_value <= '0;
            rsp.entry_last  <= 1'b1;
            rsp.list_length <= '0;
            rsp.status      <= ST_EMPTY;
          end else begin
            // words follow from the dump state; the slot drains meanwhile
            rsp.valid <= 1'b0;
            state     <= S_DUMP;
            dump_idx  <= '0;
          end
        end else begin
          rsp.valid       <= 1'b1;
          rsp.entry_value <= '0;
          rsp.entry_last  <= 1'b1;
          rsp.list_length <= len_t'(count_next);
          rsp.status      <= ins_status;
        end
      end else if (dump_step) begin
        rsp.valid       <= 1'b1;
        rsp.entry_value <= cell_q[0];
        rsp.entry_last  <= dump_last;
        rsp.list_length <= len_t'(count);
        rsp.status      <= ST_OK;
        dump_idx        <= dump_idx + count_t'(1);
        if (dump_last) begin
          state <= S_IDLE;
        end
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

/* tb/tb.sv */
// Testbench for the ordered list insert buffer: shadow list, random traffic, word checks.
module tb;
  import olib_pkg::*;

  typedef struct {
    value_t  entry_value;
    logic    entry_last;
    len_t    list_length;
    status_t status;
  } list_word_t;

  // Shadow copy of the list; predicts the response words of every accepted op.
  class list_shadow;
    value_t     cells[LIST_DEPTH];
    count_t     fill;
    list_word_t due_words[$];
    int         errors;

    function new();
      fill   = '0;
      errors = 0;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("tb: mismatch: %s", what);
    endtask

    function void place(int idx, value_t v);
      for (int i = int'(fill); i > idx; i--) cells[i] = cells[i-1];
      cells[idx] = v;
      fill++;
    endfunction

    function void push_word(value_t v, logic last, status_t st);
      list_word_t w;
      w.entry_value = v;
      w.entry_last  = last;
      w.list_length = len_t'(fill);
      w.status      = st;
      due_words.push_back(w);
    endfunction

    function void apply_op(opcode_t op, value_t v, pos_t pos);
      status_t st;
      st = ST_OK;
      if (op == OP_DUMP) begin
        if (fill == 0) push_word('0, 1'b1, ST_EMPTY);
        else
          for (int i = 0; i < int'(fill); i++)
            push_word(cells[i], i == int'(fill) - 1, ST_OK);
        return;
      end
      // full check wins over the position check
      if (int'(fill) >= LIST_DEPTH) st = ST_FULL;
      else if (op == OP_FRONT) place(0, v);
      else if (op == OP_BACK) place(int'(fill), v);
      else if (pos == 1) place(0, v);
      else if (pos >= 2 && pos <= fill) place(int'(pos) - 1, v);
      else st = ST_RANGE;
      push_word('0, 1'b1, st);
    endfunction

    task match_word(value_t v, logic last, len_t len, status_t st);
      list_word_t w;
      if (due_words.size() == 0) begin
        report($sformatf("unexpected word value=%0d last=%0b len=%0d status=%s",
                         v, last, len, st.name()));
        return;
      end
      w = due_words.pop_front();
      if (v !== w.entry_value)
        report($sformatf("entry_value %0d, want %0d", v, w.entry_value));
      if (last !== w.entry_last)
        report($sformatf("entry_last %0b, want %0b", last, w.entry_last));
      if (len !== w.list_length)
        report($sformatf("list_length %0d, want %0d", len, w.list_length));
      if (st !== w.status)
        report($sformatf("status %0d, want %0d", st, w.status));
    endtask
  endclass

  logic clk;
  logic rst;

  olib_req_if req_ch();
  olib_rsp_if rsp_ch();

  ordered_list_insert_buffer_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_shadow shadow;
  int         hold_cycles;
  bit         snd_quiet;
  bit         rcv_quiet;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #6000000;
    $display("tb: FAIL");
    $finish;
  end

  function int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function value_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'sh7fffffff;
    if (r < 6) return 32'sh80000000;
    if (r < 8) return '0;
    if (r < 10) return '1;
    return value_t'($urandom);
  endfunction

  // Called and returns just after a falling edge; valid stays high on return.
  task drive_op(opcode_t op, value_t v, pos_t pos);
    int gap;
    gap = draw_wait(snd_quiet);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.opcode   = op;
    req_ch.value    = v;
    req_ch.position = pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task settle();
    req_ch.valid = 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
  endtask

  // Monitor: note accepted ops, check accepted words.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        shadow.apply_op(req_ch.opcode, req_ch.value, req_ch.position);
      if (rsp_ch.valid && rsp_ch.ready)
        shadow.match_word(rsp_ch.entry_value, rsp_ch.entry_last, rsp_ch.list_length,
                          rsp_ch.status);
    end
  end

  // Receiver: random stalls per word, plus long hold-offs on request.
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      gap = draw_wait(rcv_quiet);
      if (gap > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid && hold_cycles == 0) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int  r;
    bit  full_done;
    shadow          = new();
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = OP_FRONT;
    req_ch.value    = '0;
    req_ch.position = '0;
    hold_cycles     = 0;
    snd_quiet       = 1'b0;
    rcv_quiet       = 1'b0;
    full_done       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty list: dump, bad positions, position one goes to the front
    drive_op(OP_DUMP, value_t'($urandom), '0);
    drive_op(OP_AT, 32'sd11, 5'd0);
    drive_op(OP_AT, 32'sd12, 5'd31);
    drive_op(OP_AT, 32'sd13, 5'd2);
    drive_op(OP_AT, 32'sh7fffffff, 5'd1);
    drive_op(OP_FRONT, 32'sh80000000, 5'd0);
    drive_op(OP_BACK, -32'sd1, 5'd16);
    drive_op(OP_BACK, 32'sd0, 5'd0);
    drive_op(OP_AT, 32'sh12345678, 5'd2);
    drive_op(OP_AT, 32'shA5A5A5A5, 5'd5);   // position equal to the length
    drive_op(OP_AT, 32'sd14, 5'd7);         // one past the length
    drive_op(OP_AT, 32'sd15, 5'd16);
    drive_op(OP_DUMP, '0, 5'd31);
    drive_op(OP_FRONT, 32'sh5A5A5A5A, 5'd31);

    for (int n = 0; n < 480; n++) begin
      if (n == 150) hold_cycles = 250;
      if (n == 300) settle();
      snd_quiet = (n >= 200 && n < 260);
      rcv_quiet = (n >= 200 && n < 260) || (n >= 380 && n < 420);
      if (!full_done && int'(shadow.fill) == LIST_DEPTH) begin
        full_done = 1'b1;
        // full list rejects every insert, before any position check
        drive_op(OP_FRONT, pick_value(), 5'd1);
        drive_op(OP_BACK, pick_value(), 5'd0);
        drive_op(OP_AT, pick_value(), 5'd0);
        drive_op(OP_AT, pick_value(), 5'd1);
        drive_op(OP_AT, pick_value(), 5'd31);
        drive_op(OP_DUMP, '0, '0);
      end
      r = $urandom_range(0, 99);
      if (int'(shadow.fill) < LIST_DEPTH) begin
        // slow growth: many rejected positions so every length sees traffic
        if (r < 30) drive_op(OP_DUMP, value_t'($urandom), pos_t'($urandom_range(0, 31)));
        else if (r < 40) drive_op(OP_FRONT, pick_value(), pos_t'($urandom_range(0, 31)));
        else if (r < 50) drive_op(OP_BACK, pick_value(), pos_t'($urandom_range(0, 31)));
        else drive_op(OP_AT, pick_value(), pos_t'($urandom_range(0, 31)));
      end else begin
        if (r < 40) drive_op(OP_DUMP, value_t'($urandom), pos_t'($urandom_range(0, 31)));
        else drive_op(opcode_t'($urandom_range(0, 2)), pick_value(),
                      pos_t'($urandom_range(0, 31)));
      end
    end

    settle();
    repeat (2 * LIST_DEPTH + 8) @(negedge clk);
    if (shadow.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
